// ===== rtl/bfec_pkg.sv =====
// bfec_pkg: shared types, constants and saturating helpers for the
// bit/frame error counter. No dependencies; imported by every rtl module.
`timescale 1ns / 1ps

package bfec_pkg;

  // word geometry
  localparam int WORD_BITS = 32;
  localparam int ONES_W    = $clog2(WORD_BITS + 1);

  // counter widths
  localparam int MISM_W  = 16;
  localparam int FRAME_W = 32;
  localparam int WIDE_W  = 48;
  localparam int ITER_W  = 40;

  // floor(x / 10) for 16-bit x: (x * 52429) >> 19 is exact over the range
  localparam logic [16:0] DIV10_RECIP = 17'd52429;
  localparam int          DIV10_SHIFT = 19;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_DETECTION_EN = 2'd0,
    CFG_MAX_FRAMES   = 2'd1,
    CFG_MIN_ERR      = 2'd2,
    CFG_UNUSED       = 2'd3
  } bfec_cfg_idx_t;

  // stop codes
  typedef enum logic [1:0] {
    STOP_CONTINUE = 2'd0,
    STOP_POINT    = 2'd1,
    STOP_ALL      = 2'd2
  } bfec_stop_t;

  // classified beat passed from front to back
  typedef struct packed {
    logic [ONES_W-1:0] ones;
    logic              last;
    logic [15:0]       f_gate;
    logic [15:0]       p_gate;
    logic              flagged;
    logic [7:0]        iters;
  } bfec_item_t;

  // configuration seen by the back end
  typedef struct packed {
    logic        detection_en;
    logic [31:0] max_frames;
    logic [15:0] min_err;
    logic [15:0] min_err_div10;
  } bfec_cfg_t;

  function automatic logic [FRAME_W-1:0] sat_inc_32(input logic [FRAME_W-1:0] a);
    sat_inc_32 = (&a) ? a : a + 1'b1;
  endfunction

  function automatic logic [WIDE_W-1:0] sat_add_48(input logic [WIDE_W-1:0] a,
                                                   input logic [WIDE_W-1:0] b);
    logic [WIDE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add_48 = s[WIDE_W] ? {WIDE_W{1'b1}} : s[WIDE_W-1:0];
  endfunction

  function automatic logic [ITER_W-1:0] sat_add_40(input logic [ITER_W-1:0] a,
                                                   input logic [7:0]        b);
    logic [ITER_W:0] s;
    s = {1'b0, a} + {{(ITER_W-7){1'b0}}, b};
    sat_add_40 = s[ITER_W] ? {ITER_W{1'b1}} : s[ITER_W-1:0];
  endfunction

endpackage

// ===== rtl/bfec_front.sv =====
// bfec_front: accepts input beats, counts masked mismatches per word and
// holds the classified beat in one register. Depends on bfec_pkg.
`timescale 1ns / 1ps

module bfec_front import bfec_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_decoded_word,
  input  logic [31:0] in_reference_word,
  input  logic [31:0] in_compare_mask,
  input  logic        in_last_of_frame,
  input  logic [15:0] in_f_gate_errors,
  input  logic [15:0] in_p_gate_errors,
  input  logic        in_decoder_flagged,
  input  logic [7:0]  in_iterations,
  output logic        push_valid,
  input  logic        push_ready,
  output bfec_item_t  push_item
);

  logic             valid_r, valid_nxt;
  bfec_item_t       item_r;
  logic [31:0]      diff;
  logic [ONES_W-1:0] ones;
  logic             accept;

  // masked mismatch count of one word
  always_comb begin
    diff = (in_decoded_word ^ in_reference_word) & in_compare_mask;
    ones = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      ones = ones + {{(ONES_W-1){1'b0}}, diff[i]};
    end
  end

  // handshake: stage frees when its beat moves into the queue
  assign in_ready = !valid_r || push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.ones    <= ones;
      item_r.last    <= in_last_of_frame;
      item_r.f_gate  <= in_f_gate_errors;
      item_r.p_gate  <= in_p_gate_errors;
      item_r.flagged <= in_decoder_flagged;
      item_r.iters   <= in_iterations;
    end
  end

  assign push_valid = valid_r;
  assign push_item  = item_r;

endmodule

// ===== rtl/bfec_queue.sv =====
// bfec_queue: two-entry queue between front and back so each side can
// stall on its own. Depends on bfec_pkg.
`timescale 1ns / 1ps

module bfec_queue import bfec_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  bfec_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output bfec_item_t pop_item
);

  bfec_item_t  slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/bfec_back.sv =====
// bfec_back: accumulates the open frame, closes it on the last beat,
// updates the saturating counters, decides the stop code and holds the
// result in an output register. Depends on bfec_pkg.
`timescale 1ns / 1ps

module bfec_back import bfec_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  bfec_cfg_t          cfg,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  bfec_item_t         pop_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_stop_code,
  output logic [FRAME_W-1:0] out_frames,
  output logic [WIDE_W-1:0]  out_bit_errors,
  output logic [FRAME_W-1:0] out_error_frames,
  output logic [WIDE_W-1:0]  out_f_gate_total,
  output logic [WIDE_W-1:0]  out_p_gate_total,
  output logic [FRAME_W-1:0] out_detected,
  output logic [FRAME_W-1:0] out_undetected,
  output logic [FRAME_W-1:0] out_false_alarms,
  output logic [ITER_W-1:0]  out_iteration_total
);

  // running counters
  logic [MISM_W-1:0]  mism_r, mism_nxt;
  logic [FRAME_W-1:0] frames_r, frames_nxt;
  logic [WIDE_W-1:0]  bits_r, bits_nxt;
  logic [FRAME_W-1:0] eframes_r, eframes_nxt;
  logic [WIDE_W-1:0]  fgate_r, fgate_nxt;
  logic [WIDE_W-1:0]  pgate_r, pgate_nxt;
  logic [FRAME_W-1:0] det_r, det_nxt;
  logic [FRAME_W-1:0] undet_r, undet_nxt;
  logic [FRAME_W-1:0] falarm_r, falarm_nxt;
  logic [ITER_W-1:0]  iter_r, iter_nxt;

  // output register
  logic               ovalid_r, ovalid_nxt;
  bfec_stop_t         ocode_r;
  logic [FRAME_W-1:0] oframes_r, oeframes_r, odet_r, oundet_r, ofalarm_r;
  logic [WIDE_W-1:0]  obits_r, ofgate_r, opgate_r;
  logic [ITER_W-1:0]  oiter_r;

  // closing values
  logic [MISM_W:0]    mism_sum;
  logic [MISM_W-1:0]  mism_new;
  logic               erroneous;
  logic [FRAME_W-1:0] c_frames, c_eframes, c_det, c_undet, c_falarm;
  logic [WIDE_W-1:0]  c_bits, c_fgate, c_pgate;
  logic [ITER_W-1:0]  c_iter;
  logic               stop, stop_all;
  bfec_stop_t         code;
  logic               take, close;

  // a closing beat needs a free output register; others always drain
  assign pop_ready = !pop_item.last || !ovalid_r || out_ready;
  assign take      = pop_valid && pop_ready;
  assign close     = take && pop_item.last;

  // open frame mismatch count, saturating at 16 bits
  always_comb begin
    mism_sum = {1'b0, mism_r} + {{(MISM_W+1-ONES_W){1'b0}}, pop_item.ones};
    mism_new = mism_sum[MISM_W] ? {MISM_W{1'b1}} : mism_sum[MISM_W-1:0];
  end

  // frame close: counter updates and stop decision
  always_comb begin
    erroneous = (mism_new != '0);
    c_frames  = sat_inc_32(frames_r);
    c_bits    = sat_add_48(bits_r, {{(WIDE_W-MISM_W){1'b0}}, mism_new});
    c_eframes = erroneous ? sat_inc_32(eframes_r) : eframes_r;
    c_fgate   = sat_add_48(fgate_r, {{(WIDE_W-16){1'b0}}, pop_item.f_gate});
    c_pgate   = sat_add_48(pgate_r, {{(WIDE_W-16){1'b0}}, pop_item.p_gate});
    c_iter    = sat_add_40(iter_r, pop_item.iters);
    c_det     = det_r;
    c_undet   = undet_r;
    c_falarm  = falarm_r;
    if (cfg.detection_en) begin
      if (erroneous && pop_item.flagged) begin
        c_det = sat_inc_32(det_r);
      end else if (erroneous) begin
        c_undet = sat_inc_32(undet_r);
      end else if (pop_item.flagged) begin
        c_falarm = sat_inc_32(falarm_r);
      end
    end
    stop     = (c_eframes >= {16'd0, cfg.min_err}) || (c_frames >= cfg.max_frames);
    stop_all = stop && (c_eframes <= {16'd0, cfg.min_err_div10});
    if (stop_all) begin
      code = STOP_ALL;
    end else if (stop) begin
      code = STOP_POINT;
    end else begin
      code = STOP_CONTINUE;
    end
  end

  // next counter state
  always_comb begin
    mism_nxt    = mism_r;
    frames_nxt  = frames_r;
    bits_nxt    = bits_r;
    eframes_nxt = eframes_r;
    fgate_nxt   = fgate_r;
    pgate_nxt   = pgate_r;
    det_nxt     = det_r;
    undet_nxt   = undet_r;
    falarm_nxt  = falarm_r;
    iter_nxt    = iter_r;
    if (close) begin
      mism_nxt = '0;
      if (stop) begin
        frames_nxt  = '0;
        bits_nxt    = '0;
        eframes_nxt = '0;
        fgate_nxt   = '0;
        pgate_nxt   = '0;
        det_nxt     = '0;
        undet_nxt   = '0;
        falarm_nxt  = '0;
        iter_nxt    = '0;
      end else begin
        frames_nxt  = c_frames;
        bits_nxt    = c_bits;
        eframes_nxt = c_eframes;
        fgate_nxt   = c_fgate;
        pgate_nxt   = c_pgate;
        det_nxt     = c_det;
        undet_nxt   = c_undet;
        falarm_nxt  = c_falarm;
        iter_nxt    = c_iter;
      end
    end else if (take) begin
      mism_nxt = mism_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mism_r    <= '0;
      frames_r  <= '0;
      bits_r    <= '0;
      eframes_r <= '0;
      fgate_r   <= '0;
      pgate_r   <= '0;
      det_r     <= '0;
      undet_r   <= '0;
      falarm_r  <= '0;
      iter_r    <= '0;
    end else begin
      mism_r    <= mism_nxt;
      frames_r  <= frames_nxt;
      bits_r    <= bits_nxt;
      eframes_r <= eframes_nxt;
      fgate_r   <= fgate_nxt;
      pgate_r   <= pgate_nxt;
      det_r     <= det_nxt;
      undet_r   <= undet_nxt;
      falarm_r  <= falarm_nxt;
      iter_r    <= iter_nxt;
    end
  end

  // output beat valid
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (close) begin
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (close) begin
      ocode_r    <= code;
      oframes_r  <= c_frames;
      obits_r    <= c_bits;
      oeframes_r <= c_eframes;
      ofgate_r   <= c_fgate;
      opgate_r   <= c_pgate;
      odet_r     <= c_det;
      oundet_r   <= c_undet;
      ofalarm_r  <= c_falarm;
      oiter_r    <= c_iter;
    end
  end

  assign out_valid           = ovalid_r;
  assign out_stop_code       = ocode_r;
  assign out_frames          = oframes_r;
  assign out_bit_errors      = obits_r;
  assign out_error_frames    = oeframes_r;
  assign out_f_gate_total    = ofgate_r;
  assign out_p_gate_total    = opgate_r;
  assign out_detected        = odet_r;
  assign out_undetected      = oundet_r;
  assign out_false_alarms    = ofalarm_r;
  assign out_iteration_total = oiter_r;

endmodule

// ===== rtl/bit_frame_error_counter_core.sv =====
// Bit/frame error counter top level: configuration registers, front
// classifier, queue and back accumulator. Depends on bfec_pkg, bfec_front,
// bfec_queue and bfec_back.
//
// Usage: each in_ beat carries one 32-bit decoded word, its reference word
// and a compare mask; masked mismatches add to the open frame. The beat with
// in_last_of_frame closes the frame and, with its gate-error counts, flag and
// iteration count, produces exactly one out_ beat with all counters and a
// stop code (0 continue, 1 stop point, 2 stop all). Other beats give none.
// After a nonzero stop code every counter restarts from zero.
// Throughput: one beat per clock while out_ready is high, including
// back-to-back closing beats. A closing beat passes through the front
// register, a queue slot and the output register before out_valid rises.
// When out_ready is low the result holds; non-closing beats keep draining,
// the next closing beat waits at the queue head, and in_ready drops once
// the queue and front register are full.
// Reset (rst_n low, synchronous) clears all counters and restores
// detection_enabled = 1, max_frames = 1000000, min_error_frames = 100.
// cfg_ beats are always taken; write them only while the block is idle.
`timescale 1ns / 1ps

module bit_frame_error_counter_core import bfec_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_decoded_word,
  input  logic [31:0]        in_reference_word,
  input  logic [31:0]        in_compare_mask,
  input  logic               in_last_of_frame,
  input  logic [15:0]        in_f_gate_errors,
  input  logic [15:0]        in_p_gate_errors,
  input  logic               in_decoder_flagged,
  input  logic [7:0]         in_iterations,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_stop_code,
  output logic [31:0]        out_frames,
  output logic [47:0]        out_bit_errors,
  output logic [31:0]        out_error_frames,
  output logic [47:0]        out_f_gate_total,
  output logic [47:0]        out_p_gate_total,
  output logic [31:0]        out_detected,
  output logic [31:0]        out_undetected,
  output logic [31:0]        out_false_alarms,
  output logic [39:0]        out_iteration_total
);

  bfec_cfg_t   cfg_r, cfg_nxt;
  logic [34:0] div10_prod;
  logic        cfg_we;
  logic        push_valid, push_ready, pop_valid, pop_ready;
  bfec_item_t  push_item, pop_item;

  // configuration registers; min_err / 10 is kept alongside
  assign cfg_ready  = 1'b1;
  assign cfg_we     = cfg_valid && cfg_ready;
  assign div10_prod = {19'd0, cfg_data[15:0]} * {18'd0, DIV10_RECIP};

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (bfec_cfg_idx_t'(cfg_index))
        CFG_DETECTION_EN: cfg_nxt.detection_en = cfg_data[0];
        CFG_MAX_FRAMES:   cfg_nxt.max_frames = cfg_data;
        CFG_MIN_ERR: begin
          cfg_nxt.min_err       = cfg_data[15:0];
          cfg_nxt.min_err_div10 = div10_prod[DIV10_SHIFT +: 16];
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.detection_en  <= 1'b1;
      cfg_r.max_frames    <= 32'd1000000;
      cfg_r.min_err       <= 16'd100;
      cfg_r.min_err_div10 <= 16'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: accept and classify
  bfec_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_decoded_word    (in_decoded_word),
    .in_reference_word  (in_reference_word),
    .in_compare_mask    (in_compare_mask),
    .in_last_of_frame   (in_last_of_frame),
    .in_f_gate_errors   (in_f_gate_errors),
    .in_p_gate_errors   (in_p_gate_errors),
    .in_decoder_flagged (in_decoder_flagged),
    .in_iterations      (in_iterations),
    .push_valid         (push_valid),
    .push_ready         (push_ready),
    .push_item          (push_item)
  );

  // decoupling queue
  bfec_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // back: accumulate, close frames, report
  bfec_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .pop_valid           (pop_valid),
    .pop_ready           (pop_ready),
    .pop_item            (pop_item),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_stop_code       (out_stop_code),
    .out_frames          (out_frames),
    .out_bit_errors      (out_bit_errors),
    .out_error_frames    (out_error_frames),
    .out_f_gate_total    (out_f_gate_total),
    .out_p_gate_total    (out_p_gate_total),
    .out_detected        (out_detected),
    .out_undetected      (out_undetected),
    .out_false_alarms    (out_false_alarms),
    .out_iteration_total (out_iteration_total)
  );

`ifndef SYNTHESIS
  // every reported frame count includes the closing frame
  a_frames_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frames != 32'd0)
    else $error("result with zero frame count");

  // erroneous frames never outnumber frames
  a_eframes_le_frames: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error_frames <= out_frames)
    else $error("error frame count above frame count");

  // stop code is one of the three defined codes
  a_stop_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_stop_code == STOP_CONTINUE || out_stop_code == STOP_POINT ||
                   out_stop_code == STOP_ALL))
    else $error("illegal stop code");

  // an empty queue with a free front stage always takes a beat
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (!push_valid && !pop_valid) |-> in_ready)
    else $error("input stalled with empty pipeline");
`endif

endmodule
